### rtl/sxd_pkg.sv
package sxd_pkg;

    localparam int TABLE_LEN    = 59;
    localparam int OPCODE_COUNT = 59;
    localparam int SEARCH_LEN   = (OPCODE_COUNT < TABLE_LEN) ? OPCODE_COUNT : TABLE_LEN;

    localparam int ADDR_W = 20;
    localparam int IDX_W  = 6;

    localparam logic [7:0] OP_TABLE [TABLE_LEN] = '{
        8'h18, 8'h58, 8'h90, 8'h40, 8'hB4, 8'h28,
        8'h88, 8'hA0, 8'h24, 8'h64, 8'h9C, 8'hC4,
        8'hC0, 8'hF4, 8'h3C, 8'h30, 8'h34, 8'h38,
        8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08,
        8'h6C, 8'h74, 8'h04, 8'hD0, 8'h20, 8'h60,
        8'h98, 8'hC8, 8'h44, 8'hD8, 8'hAC, 8'h4C,
        8'hA4, 8'hA8, 8'hF0, 8'hEC, 8'h0C, 8'h78,
        8'h54, 8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8,
        8'h84, 8'h10, 8'h1C, 8'h5C, 8'h94, 8'hB0,
        8'hE0, 8'hF8, 8'h2C, 8'hB8, 8'hDC
    };

    // mnemonic indices that are two-byte register instructions
    localparam logic [63:0] FMT2_SET =
        (64'd1 << 2)  | (64'd1 << 4)  | (64'd1 << 7)  | (64'd1 << 10) |
        (64'd1 << 30) | (64'd1 << 34) | (64'd1 << 36) | (64'd1 << 37) |
        (64'd1 << 52) | (64'd1 << 53) | (64'd1 << 57);

    localparam logic [IDX_W-1:0] IDX_CLEAR = 6'd4;
    localparam logic [IDX_W-1:0] IDX_LDB   = 6'd20;
    localparam logic [IDX_W-1:0] IDX_LDX   = 6'd26;

    localparam logic [3:0] REG_NUM_X = 4'd1;
    localparam logic [3:0] REG_NUM_B = 4'd3;

    localparam logic [2:0] LEN_FMT2 = 3'd2;
    localparam logic [2:0] LEN_FMT3 = 3'd3;
    localparam logic [2:0] LEN_FMT4 = 3'd4;

    localparam logic [1:0] OPM_SIMPLE    = 2'd0;
    localparam logic [1:0] OPM_IMMEDIATE = 2'd1;
    localparam logic [1:0] OPM_INDIRECT  = 2'd2;

    localparam logic [1:0] REL_DIRECT = 2'd0;
    localparam logic [1:0] REL_PC     = 2'd1;
    localparam logic [1:0] REL_BASE   = 2'd2;
    localparam logic [1:0] REL_BOTH   = 2'd3;

    typedef struct packed {
        logic [31:0]       instruction_word;
        logic [ADDR_W-1:0] location;
    } sxd_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  opcode_index;
        logic [2:0]        length;
        logic [ADDR_W-1:0] target_address;
        logic [1:0]        operand_mode;
        logic [1:0]        relative_mode;
        logic              indexed;
        logic              operand_is_constant;
        logic [ADDR_W-1:0] constant_value;
        logic [3:0]        first_register;
    } sxd_out_t;

    typedef struct packed {
        logic              load_base;
        logic              load_index;
        logic              clear_base;
        logic              clear_index;
        logic [ADDR_W-1:0] value;
    } sxd_reg_upd_t;

endpackage

### rtl/sxd_opcode_lookup.sv
module sxd_opcode_lookup
    import sxd_pkg::*;
(
    input  logic [5:0]       opcode_bits,
    output logic [IDX_W-1:0] opcode_index
);

    // first match wins, so scan from the top down
    always_comb
    begin
        opcode_index = '0;
        for (int i = SEARCH_LEN - 1; i >= 0; i--)
        begin
            if (OP_TABLE[i][7:2] == opcode_bits)
            begin
                opcode_index = IDX_W'(i);
            end
        end
    end

endmodule

### rtl/sxd_decode_unit.sv
module sxd_decode_unit
    import sxd_pkg::*;
(
    input  sxd_in_t           word_in,
    input  logic [ADDR_W-1:0] base_value,
    input  logic [ADDR_W-1:0] index_value,
    output sxd_out_t          result,
    output sxd_reg_upd_t      reg_upd
);

    logic [IDX_W-1:0]  opcode_index;
    logic [31:0]       w;
    logic              fmt2;
    logic              n_bit, i_bit, x_bit, b_bit, p_bit, e_bit;
    logic [2:0]        len;
    logic [ADDR_W-1:0] cval;
    logic [ADDR_W-1:0] disp;
    logic [1:0]        rmode;
    logic              use_index;
    logic              is_const;
    logic [ADDR_W-1:0] ta_base;
    logic [ADDR_W-1:0] ta;

    assign w = word_in.instruction_word;

    sxd_opcode_lookup u_lookup (
        .opcode_bits  (w[31:26]),
        .opcode_index (opcode_index)
    );

    assign fmt2  = FMT2_SET[opcode_index];
    assign n_bit = w[25];
    assign i_bit = w[24];
    assign x_bit = w[23];
    assign b_bit = w[22];
    assign p_bit = w[21];
    assign e_bit = w[20];

    always_comb
    begin
        if (fmt2)
        begin
            len = LEN_FMT2;
        end
        else if (e_bit)
        begin
            len = LEN_FMT4;
        end
        else
        begin
            len = LEN_FMT3;
        end
    end

    // disp12 is sign-extended, the 20-bit address is taken as is
    always_comb
    begin
        if (e_bit)
        begin
            cval = w[19:0];
            disp = w[19:0];
        end
        else
        begin
            cval = {8'd0, w[19:8]};
            disp = {{8{w[19]}}, w[19:8]};
        end
    end

    assign rmode     = {b_bit, p_bit};
    assign use_index = x_bit && !(b_bit && p_bit);
    assign is_const  = !e_bit && !b_bit && !p_bit;

    always_comb
    begin
        unique case (rmode)
            REL_PC:     ta_base = disp + word_in.location + ADDR_W'(len);
            REL_BASE:   ta_base = disp + base_value;
            REL_DIRECT: ta_base = disp;
            default:    ta_base = '0;
        endcase
    end

    assign ta = use_index ? ta_base + index_value : ta_base;

    always_comb
    begin
        result              = '0;
        result.opcode_index = opcode_index;
        result.length       = len;
        if (fmt2)
        begin
            result.first_register = w[23:20];
        end
        else
        begin
            result.target_address      = ta;
            result.relative_mode       = rmode;
            result.indexed             = use_index;
            result.operand_is_constant = is_const;
            result.constant_value      = cval;
            if (!n_bit && i_bit)
            begin
                result.operand_mode = OPM_IMMEDIATE;
            end
            else if (n_bit && !i_bit)
            begin
                result.operand_mode = OPM_INDIRECT;
            end
            else
            begin
                result.operand_mode = OPM_SIMPLE;
            end
        end
    end

    always_comb
    begin
        reg_upd             = '0;
        reg_upd.value       = is_const ? cval : ta;
        reg_upd.load_base   = (opcode_index == IDX_LDB);
        reg_upd.load_index  = (opcode_index == IDX_LDX);
        reg_upd.clear_index = (opcode_index == IDX_CLEAR) && (w[23:20] == REG_NUM_X);
        reg_upd.clear_base  = (opcode_index == IDX_CLEAR) && (w[23:20] == REG_NUM_B);
    end

endmodule

### rtl/sxd_reg_track.sv
module sxd_reg_track
    import sxd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update_en,
    input  sxd_reg_upd_t      reg_upd,
    output logic [ADDR_W-1:0] base_value,
    output logic [ADDR_W-1:0] index_value
);

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [ADDR_W-1:0] index_reg;
    logic [ADDR_W-1:0] index_next;

    always_comb
    begin
        base_next  = base_reg;
        index_next = index_reg;
        if (update_en)
        begin
            if (reg_upd.load_base)
            begin
                base_next = reg_upd.value;
            end
            else if (reg_upd.clear_base)
            begin
                base_next = '0;
            end
            if (reg_upd.load_index)
            begin
                index_next = reg_upd.value;
            end
            else if (reg_upd.clear_index)
            begin
                index_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            index_reg <= '0;
        end
        else
        begin
            base_reg  <= base_next;
            index_reg <= index_next;
        end
    end

    assign base_value  = base_reg;
    assign index_value = index_reg;

    a_clear_base: assert property (@(posedge clk) disable iff (!rst_n)
        update_en && reg_upd.clear_base |=> base_reg == '0)
        else $error("base register not cleared");

    a_load_index: assert property (@(posedge clk) disable iff (!rst_n)
        update_en && reg_upd.load_index |=> index_reg == $past(reg_upd.value))
        else $error("index register load lost");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update_en |=> $stable(base_reg) && $stable(index_reg))
        else $error("register changed without a decoded word");

endmodule

### rtl/sicxe_instruction_decode_core.sv
// accepted words pass the decode stage register, then the output register
// throughput: one word per cycle unless the output stalls; the base and index
// registers update as a word leaves decode; the next word sees them without a gap
// reset: asynchronous, clears both valid flags and the base and index registers to zero
module sicxe_instruction_decode_core
    import sxd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sxd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sxd_out_t out_data
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    sxd_in_t           s1_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    sxd_out_t          out_data_reg;
    logic              advance;
    logic              in_take;
    sxd_out_t          result;
    sxd_reg_upd_t      reg_upd;
    logic [ADDR_W-1:0] base_value;
    logic [ADDR_W-1:0] index_value;

    // decode stage moves on when the output register is free or being emptied
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    sxd_decode_unit u_decode (
        .word_in     (s1_data_reg),
        .base_value  (base_value),
        .index_value (index_value),
        .result      (result),
        .reg_upd     (reg_upd)
    );

    sxd_reg_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .update_en   (advance),
        .reg_upd     (reg_upd),
        .base_value  (base_value),
        .index_value (index_value)
    );

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### verif/sicxe_instruction_decode_checker.sv
module sicxe_instruction_decode_checker
    import sxd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  sxd_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  sxd_out_t out_data,
    output int       error_count,
    output int       pending_words,
    output int       words_checked,
    output int       reg_updates,
    output int       base_relative_words,
    output int       indexed_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DECODE_ENTRIES = 59;
    localparam int REG_FORM_COUNT = 11;
    localparam int PRINT_CAP      = 40;

    // mnemonic table, searched from the front
    localparam logic [7:0] DECODE_TABLE [DECODE_ENTRIES] = '{
        8'h18, 8'h58, 8'h90, 8'h40, 8'hB4, 8'h28,
        8'h88, 8'hA0, 8'h24, 8'h64, 8'h9C, 8'hC4,
        8'hC0, 8'hF4, 8'h3C, 8'h30, 8'h34, 8'h38,
        8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08,
        8'h6C, 8'h74, 8'h04, 8'hD0, 8'h20, 8'h60,
        8'h98, 8'hC8, 8'h44, 8'hD8, 8'hAC, 8'h4C,
        8'hA4, 8'hA8, 8'hF0, 8'hEC, 8'h0C, 8'h78,
        8'h54, 8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8,
        8'h84, 8'h10, 8'h1C, 8'h5C, 8'h94, 8'hB0,
        8'hE0, 8'hF8, 8'h2C, 8'hB8, 8'hDC
    };

    // register-to-register opcodes: addr clear compr divr mulr rmo shiftl shiftr subr svc tixr
    localparam logic [7:0] REG_FORM_OPS [REG_FORM_COUNT] = '{
        8'h90, 8'hB4, 8'hA0, 8'h9C, 8'h98, 8'hAC,
        8'hA4, 8'hA8, 8'h94, 8'hB0, 8'hB8
    };

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] index_reg;
    sxd_out_t          predicted_decodes [$];

    function automatic sxd_out_t decode_word(input sxd_in_t w);
        sxd_out_t          r;
        logic [31:0]       iw;
        logic [7:0]        op;
        logic [ADDR_W-1:0] disp;
        logic [ADDR_W-1:0] load_val;
        logic              reg_form;
        logic              bf;
        logic              pf;
        iw       = w.instruction_word;
        op       = {iw[31:26], 2'b00};
        r        = '0;
        reg_form = 1'b0;
        disp     = '0;
        for (int k = DECODE_ENTRIES - 1; k >= 0; k--)
            if (DECODE_TABLE[k] == op)
                r.opcode_index = IDX_W'(k);
        for (int k = 0; k < REG_FORM_COUNT; k++)
            if (REG_FORM_OPS[k] == op)
                reg_form = 1'b1;

        if (reg_form)
        begin
            r.length         = LEN_FMT2;
            r.first_register = iw[23:20];
        end
        else
        begin
            bf       = iw[22];
            pf       = iw[21];
            r.length = iw[20] ? LEN_FMT4 : LEN_FMT3;
            if (r.length == LEN_FMT3)
            begin
                r.constant_value = {8'h00, iw[19:8]};
                disp             = {{8{iw[19]}}, iw[19:8]};
            end
            else
            begin
                r.constant_value = iw[19:0];
                disp             = iw[19:0];
            end
            case (iw[25:24])
                2'b01:   r.operand_mode = OPM_IMMEDIATE;
                2'b10:   r.operand_mode = OPM_INDIRECT;
                default: r.operand_mode = OPM_SIMPLE;
            endcase
            case ({bf, pf})
                2'b11:   r.relative_mode = REL_BOTH;
                2'b01:   r.relative_mode = REL_PC;
                2'b10:   r.relative_mode = REL_BASE;
                default: r.relative_mode = REL_DIRECT;
            endcase
            r.indexed             = iw[23] && !(bf && pf);
            r.operand_is_constant = (r.length == LEN_FMT3) && !bf && !pf;
            case (r.relative_mode)
                REL_PC:   r.target_address = disp + w.location + ADDR_W'(r.length);
                REL_BASE: r.target_address = disp + base_reg;
                REL_BOTH: r.target_address = '0;
                default:  r.target_address = disp;
            endcase
            if (r.indexed)
                r.target_address = r.target_address + index_reg;
        end

        // register tracking uses the address just worked out
        load_val = r.operand_is_constant ? r.constant_value : r.target_address;
        if (r.opcode_index == IDX_LDB)
            base_reg = load_val;
        else if (r.opcode_index == IDX_LDX)
            index_reg = load_val;
        else if (r.opcode_index == IDX_CLEAR)
        begin
            if (r.first_register == REG_NUM_X)
                index_reg = '0;
            else if (r.first_register == REG_NUM_B)
                base_reg = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < PRINT_CAP)
            $display("[%0t] word %0d %s: expected 0x%0h, got 0x%0h",
                     $time, words_checked, what, want, got);
        error_count++;
    endtask

    task automatic compare_word(input sxd_out_t got, input sxd_out_t want);
        if (got.opcode_index !== want.opcode_index)
            report_mismatch("opcode_index", 32'(want.opcode_index),
                            32'(got.opcode_index));
        if (got.length !== want.length)
            report_mismatch("length", 32'(want.length), 32'(got.length));
        if (got.target_address !== want.target_address)
            report_mismatch("target_address", 32'(want.target_address),
                            32'(got.target_address));
        if (got.operand_mode !== want.operand_mode)
            report_mismatch("operand_mode", 32'(want.operand_mode),
                            32'(got.operand_mode));
        if (got.relative_mode !== want.relative_mode)
            report_mismatch("relative_mode", 32'(want.relative_mode),
                            32'(got.relative_mode));
        if (got.indexed !== want.indexed)
            report_mismatch("indexed", 32'(want.indexed), 32'(got.indexed));
        if (got.operand_is_constant !== want.operand_is_constant)
            report_mismatch("operand_is_constant", 32'(want.operand_is_constant),
                            32'(got.operand_is_constant));
        if (got.constant_value !== want.constant_value)
            report_mismatch("constant_value", 32'(want.constant_value),
                            32'(got.constant_value));
        if (got.first_register !== want.first_register)
            report_mismatch("first_register", 32'(want.first_register),
                            32'(got.first_register));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sxd_out_t want;
        if (!rst_n)
        begin
            predicted_decodes.delete();
            base_reg  = '0;
            index_reg = '0;
            pending_words <= 0;
        end
        else
        begin
            // the result leaving now always belongs to an earlier word
            if (out_valid && out_ready)
            begin
                if (predicted_decodes.size() == 0)
                    report_mismatch("word with nothing expected", '0,
                                    32'(out_data.target_address));
                else
                begin
                    want = predicted_decodes.pop_front();
                    compare_word(out_data, want);
                    words_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                want = decode_word(in_data);
                predicted_decodes = {predicted_decodes, want};
                if (want.opcode_index == IDX_LDB || want.opcode_index == IDX_LDX ||
                    want.opcode_index == IDX_CLEAR)
                    reg_updates++;
                if (want.relative_mode == REL_BASE)
                    base_relative_words++;
                if (want.indexed)
                    indexed_words++;
            end
            pending_words <= predicted_decodes.size();
        end
    end

endmodule

### verif/sicxe_instruction_decode_core_test.sv
module sicxe_instruction_decode_core_test;
    import sxd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 300;
    localparam int BURST_WORDS   = 60;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_LIMIT    = 1000;
    localparam int TAIL_CYCLES   = 10;

    typedef enum logic [7:0] {
        OPC_LDA     = 8'h00,
        OPC_LDX     = 8'h04,
        OPC_J       = 8'h3C,
        OPC_LDB     = 8'h68,
        OPC_DIVR    = 8'h9C,
        OPC_CLEAR   = 8'hB4,
        OPC_NONE_8C = 8'h8C,
        OPC_NONE_BC = 8'hBC,
        OPC_NONE_CC = 8'hCC,
        OPC_NONE_E4 = 8'hE4,
        OPC_NONE_FC = 8'hFC
    } opcode_t;

    localparam logic [1:0] NI_OLD = 2'b00;
    localparam logic [1:0] NI_IMM = 2'b01;
    localparam logic [1:0] NI_IND = 2'b10;
    localparam logic [1:0] NI_STD = 2'b11;

    localparam logic [3:0] FL_NONE = 4'b0000;
    localparam logic [3:0] FL_X    = 4'b1000;
    localparam logic [3:0] FL_B    = 4'b0100;
    localparam logic [3:0] FL_P    = 4'b0010;
    localparam logic [3:0] FL_E    = 4'b0001;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    sxd_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    sxd_out_t out_data;

    int error_count;
    int pending_words;
    int words_checked;
    int reg_updates;
    int base_relative_words;
    int indexed_words;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    sicxe_instruction_decode_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sicxe_instruction_decode_checker u_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .in_data             (in_data),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_data            (out_data),
        .error_count         (error_count),
        .pending_words       (pending_words),
        .words_checked       (words_checked),
        .reg_updates         (reg_updates),
        .base_relative_words (base_relative_words),
        .indexed_words       (indexed_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] fmt3(input logic [7:0] op, input logic [1:0] ni,
                                         input logic [3:0] fl, input logic [11:0] disp);
        return {op[7:2], ni, fl, disp, 8'($urandom)};
    endfunction

    function automatic logic [31:0] fmt4(input logic [7:0] op, input logic [1:0] ni,
                                         input logic [3:0] fl, input logic [19:0] addr);
        return {op[7:2], ni, fl | FL_E, addr};
    endfunction

    function automatic logic [31:0] fmt2(input logic [7:0] op, input logic [3:0] r1,
                                         input logic [3:0] r2);
        return {op, r1, r2, 16'($urandom)};
    endfunction

    function automatic logic [19:0] rand_addr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 20'hFFFFF;
            2:       return 20'hFFFFF - 20'($urandom_range(0, 15));
            default: return 20'($urandom);
        endcase
    endfunction

    // mostly plausible instructions, with register loads and clears over-weighted
    function automatic logic [31:0] rand_instruction();
        logic [7:0]  op;
        logic [3:0]  fl;
        logic [19:0] low;
        int          pick;
        if ($urandom_range(0, 99) < 8)
            return $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = OPC_LDB;
        else if (pick < 20)
            op = OPC_LDX;
        else if (pick < 30)
            op = OPC_CLEAR;
        else
            op = {6'($urandom_range(0, 63)), 2'b00};
        fl = 4'($urandom);
        if ($urandom_range(0, 3) != 0)
            fl = fl & ~FL_E;
        if (op == OPC_CLEAR && $urandom_range(0, 2) != 0)
            fl = $urandom_range(0, 1) ? REG_NUM_X : REG_NUM_B;
        low = rand_addr();
        if (low != 0 && low != 20'hFFFFF && $urandom_range(0, 4) == 0)
            low[19:8] = $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
        return {op[7:2], 2'($urandom), fl, low};
    endfunction

    task automatic send_word(input logic [31:0] word, input logic [19:0] loc, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {word, loc};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    // receiver: random stalls, or one long hold when asked
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        int idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("sicxe_instruction_decode_core_test: errors");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes first
        send_word(32'h0000_0000, 20'h00000, pick_gap());
        send_word(32'hFFFF_FFFF, 20'hFFFFF, pick_gap());
        // register loads from constants, then base and index in use
        send_word(fmt3(OPC_LDB, NI_IMM, FL_NONE, 12'h800), 20'h00100, pick_gap());
        send_word(fmt3(OPC_LDX, NI_IMM, FL_NONE, 12'hFFF), 20'h00103, pick_gap());
        send_word(fmt3(OPC_LDA, NI_STD, FL_X | FL_B, 12'hFFF), 20'h00106, pick_gap());
        send_word(fmt3(OPC_J, NI_STD, FL_P, 12'h800), 20'h00010, pick_gap());
        send_word(fmt3(OPC_LDA, NI_STD, FL_X | FL_P, 12'h7FF), 20'hFFFFF, pick_gap());
        // b and p together: no target, not indexed
        send_word(fmt3(OPC_LDA, NI_IND, FL_X | FL_B | FL_P, 12'h123), 20'h00200, pick_gap());
        send_word(fmt4(OPC_J, NI_STD, FL_P, 20'hFFFFF), 20'hFFFFE, pick_gap());
        // loads from computed targets
        send_word(fmt4(OPC_LDB, NI_STD, FL_NONE, 20'h12345), 20'h00300, pick_gap());
        send_word(fmt3(OPC_LDX, NI_STD, FL_B, 12'h010), 20'h00304, pick_gap());
        send_word(fmt3(OPC_LDA, NI_OLD, FL_X | FL_B, 12'h001), 20'h00307, pick_gap());
        // clear by register number, including numbers that do nothing
        send_word(fmt2(OPC_CLEAR, REG_NUM_X, 4'h0), 20'h00400, pick_gap());
        send_word(fmt2(OPC_CLEAR, 4'h0, 4'h0), 20'h00402, pick_gap());
        send_word(fmt2(OPC_CLEAR, 4'hF, 4'hF), 20'h00404, pick_gap());
        send_word(fmt3(OPC_LDA, NI_STD, FL_X | FL_B, 12'h002), 20'h00406, pick_gap());
        send_word(fmt2(OPC_CLEAR, REG_NUM_B, 4'h0), 20'h00409, pick_gap());
        send_word(fmt3(OPC_LDA, NI_STD, FL_X | FL_B, 12'h003), 20'h0040B, pick_gap());
        send_word(fmt2(OPC_DIVR, 4'h2, 4'h3), 20'h00500, pick_gap());
        // opcodes missing from the table
        send_word(fmt3(OPC_NONE_8C, NI_STD, FL_P, 12'h040), 20'h00600, pick_gap());
        send_word(fmt4(OPC_NONE_BC, NI_IMM, FL_NONE, 20'h00ABC), 20'h00603, pick_gap());
        send_word(fmt3(OPC_NONE_CC, NI_IND, FL_X, 12'h800), 20'h00607, pick_gap());
        send_word(fmt2(OPC_NONE_E4, REG_NUM_B, 4'h1), 20'h0060A, pick_gap());
        // indirect constant load, then a format 4 indexed load
        send_word(fmt3(OPC_LDB, NI_IND, FL_NONE, 12'h7FF), 20'h00700, pick_gap());
        send_word(fmt4(OPC_LDX, NI_STD, FL_X, 20'hFFFFF), 20'h00703, pick_gap());
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm = (ph == 1 || ph == 4);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // long output hold while input keeps coming back to back
                if (ph == 2 && k == 0)
                    hold_req = 1'b1;
                if (ph == 2 && k < BURST_WORDS)
                    send_word(rand_instruction(), rand_addr(), 0);
                else
                    send_word(rand_instruction(), rand_addr(), pick_gap());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("decoded %0d words, %0d of them base or index loads and clears",
                 words_checked, reg_updates);
        $display("%0d base-relative, %0d indexed, with random stalls and one long output hold",
                 base_relative_words, indexed_words);
        if (error_count == 0)
            $display("sicxe_instruction_decode_core_test: clean");
        else
            $display("sicxe_instruction_decode_core_test: errors");
        $finish;
    end

endmodule
